// ----- hw/rtl/bmpd_pkg.sv -----
// ----------------------------------------------------------------------------
// BMP decoder package
// Shared types, header layout constants and header check functions.
// ----------------------------------------------------------------------------
package bmpd_pkg;

   localparam int unsigned MAX_DIM    = 4096;
   localparam int unsigned COORD_W    = 12;
   localparam int unsigned DIM_W      = 13;
   localparam int unsigned HEADER_LEN = 34;

   localparam logic [7:0] CHAR_B = 8'h42;
   localparam logic [7:0] CHAR_M = 8'h4D;

   localparam logic [5:0] POS_SIG_B     = 6'd0;
   localparam logic [5:0] POS_SIG_M     = 6'd1;
   localparam logic [5:0] POS_OFFSET_0  = 6'd10;
   localparam logic [5:0] POS_OFFSET_1  = 6'd11;
   localparam logic [5:0] POS_OFFSET_2  = 6'd12;
   localparam logic [5:0] POS_OFFSET_3  = 6'd13;
   localparam logic [5:0] POS_WIDTH_0   = 6'd18;
   localparam logic [5:0] POS_WIDTH_1   = 6'd19;
   localparam logic [5:0] POS_WIDTH_2   = 6'd20;
   localparam logic [5:0] POS_WIDTH_3   = 6'd21;
   localparam logic [5:0] POS_HEIGHT_0  = 6'd22;
   localparam logic [5:0] POS_HEIGHT_1  = 6'd23;
   localparam logic [5:0] POS_HEIGHT_2  = 6'd24;
   localparam logic [5:0] POS_HEIGHT_3  = 6'd25;
   localparam logic [5:0] POS_DEPTH_0   = 6'd28;
   localparam logic [5:0] POS_DEPTH_1   = 6'd29;
   localparam logic [5:0] POS_COMP_0    = 6'd30;
   localparam logic [5:0] POS_COMP_3    = 6'd33;
   localparam logic [5:0] POS_HDR_LAST  = 6'(HEADER_LEN - 1);

   localparam logic [15:0] DEPTH_MONO = 16'd1;
   localparam logic [15:0] DEPTH_RGB  = 16'd24;

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_SKIP   = 5'b00010,
      PH_PIXELS = 5'b00100,
      PH_DONE   = 5'b01000,
      PH_ERROR  = 5'b10000
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_BMP   = 3'd1,
      ST_BAD_DIMS  = 3'd2,
      ST_BAD_DEPTH = 3'd3,
      ST_COMPRESS  = 3'd4,
      ST_TOO_LARGE = 3'd5
   } status_type;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_ERROR = 1'b1
   } kind_type;

   // Zero for a dimension that is not positive, MAX_DIM + 1 for one too large.
   function automatic logic [DIM_W-1:0] clip_dim(input logic [31:0] raw);
      logic [DIM_W-1:0] res;
      if (raw == 32'd0 || raw[31]) begin
         res = '0;
      end else if (raw > 32'(MAX_DIM)) begin
         res = DIM_W'(MAX_DIM + 1);
      end else begin
         res = raw[DIM_W-1:0];
      end
      return res;
   endfunction

   function automatic status_type check_header(input logic [DIM_W-1:0] width,
                                               input logic [DIM_W-1:0] height,
                                               input logic [31:0] shift);
      status_type res;
      if (width == '0 || height == '0) begin
         res = ST_BAD_DIMS;
      end else if (shift[15:0] != DEPTH_MONO && shift[15:0] != DEPTH_RGB) begin
         res = ST_BAD_DEPTH;
      end else if (shift[16]) begin
         res = ST_COMPRESS;
      end else if (width > DIM_W'(MAX_DIM) || height > DIM_W'(MAX_DIM)) begin
         res = ST_TOO_LARGE;
      end else begin
         res = ST_OK;
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/bmpd_if.sv -----
// ----------------------------------------------------------------------------
// BMP decoder channels
// Valid/ready channels for file bytes in and pixel or error results out.
// ----------------------------------------------------------------------------
interface bmpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       image_start;

   modport source (output valid, output data_byte, output image_start, input ready);
   modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

interface bmpd_rsp_if;
   import bmpd_pkg::*;

   logic               valid;
   logic               ready;
   logic               kind;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   logic [7:0]         red;
   logic [7:0]         green;
   logic [7:0]         blue;
   logic [2:0]         status;
   logic               last;

   modport source (output valid, output kind, output pixel_x, output pixel_y,
                   output red, output green, output blue, output status,
                   output last, input ready);
   modport sink   (input valid, input kind, input pixel_x, input pixel_y,
                   input red, input green, input blue, input status,
                   input last, output ready);
endinterface

// ----- hw/rtl/bmp_stream_pixel_decoder_top.sv -----
// ----------------------------------------------------------------------------
// BMP stream pixel decoder
// Parses an uncompressed 1-bit or 24-bit BMP file arriving one byte per
// request and emits pixel writes (bottom-up rows, row 0 at the top) or one
// error report per file.
//
// The req channel carries one file byte per request; image_start marks byte 0
// of a new file and restarts the parser. The rsp channel carries pixel writes
// and error reports; last is set on the final result caused by a byte.
// A request is held in an input register and worked on there; its first
// result goes from there into the result register before it is valid.
// Header, skip and padding bytes give no result, but for an error report.
// In 24-bit mode a new byte is accepted every cycle while the receiver does
// not stall. In 1-bit mode a byte gives one pixel per cycle, fed by the bit
// sequencer into the result register; the next byte waits until it is done.
// Bytes after an error or after the final pixel are taken and dropped.
// Reset puts the parser at byte 0 of a file, with both registers empty.
// When the receiver stalls, the result register holds its item; header and
// skip bytes still go through, and a byte that yields a result waits.
// ----------------------------------------------------------------------------
module bmp_stream_pixel_decoder_top (
   input logic       clock,
   input logic       reset,
   bmpd_req_if.sink  req_if,
   bmpd_rsp_if.source rsp_if
);
   import bmpd_pkg::*;

   logic               in_valid_ff;
   logic [7:0]         byte_ff;
   logic               start_ff;
   logic [2:0]         bit_ff, bit_in;

   logic [31:0]        bp_ff, bp_in, cur_bp;
   logic [31:0]        ds_ff, ds_in, cur_ds;
   logic [31:0]        hs_ff, hs_in, cur_hs;
   logic [DIM_W-1:0]   width_ff, width_in, cur_width;
   logic [DIM_W-1:0]   height_ff, height_in, cur_height;
   logic               mono_ff, mono_in, cur_mono;
   phase_type          phase_ff, phase_in, cur_phase;
   logic [COORD_W-1:0] col_ff, col_in, cur_col;
   logic [COORD_W-1:0] row_ff, row_in, cur_row;
   logic [1:0]         slot_ff, slot_in, cur_slot;
   logic [7:0]         blue_ff, blue_in, cur_blue;
   logic [7:0]         green_ff, green_in, cur_green;
   logic [1:0]         pad_ff, pad_in, cur_pad;

   logic [5:0]         pos;
   status_type         err;
   logic [DIM_W-1:0]   next_col, next_row;
   logic               col_wrap, row_wrap;
   logic [1:0]         pad_calc;
   logic [COORD_W-1:0] pix_y;
   logic [7:0]         mono_val;

   logic               res_valid;
   kind_type           res_kind;
   logic [COORD_W-1:0] res_x, res_y;
   logic [7:0]         res_red, res_green, res_blue;
   status_type         res_status;
   logic               item_done;
   logic               out_free, step_go, req_go;

   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [7:0]         rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [2:0]         rsp_status_ff;
   logic               rsp_last_ff;

   // A start byte sees the parser in its reset state.
   always_comb begin
      cur_bp     = start_ff ? '0 : bp_ff;
      cur_ds     = start_ff ? '0 : ds_ff;
      cur_hs     = start_ff ? '0 : hs_ff;
      cur_width  = start_ff ? '0 : width_ff;
      cur_height = start_ff ? '0 : height_ff;
      cur_mono   = start_ff ? 1'b0 : mono_ff;
      cur_phase  = start_ff ? PH_HEADER : phase_ff;
      cur_col    = start_ff ? '0 : col_ff;
      cur_row    = start_ff ? '0 : row_ff;
      cur_slot   = start_ff ? '0 : slot_ff;
      cur_blue   = start_ff ? '0 : blue_ff;
      cur_green  = start_ff ? '0 : green_ff;
      cur_pad    = start_ff ? '0 : pad_ff;
   end

   assign pos      = cur_bp[5:0];
   assign next_col = {1'b0, cur_col} + DIM_W'(1);
   assign next_row = {1'b0, cur_row} + DIM_W'(1);
   assign col_wrap = next_col >= cur_width;
   assign row_wrap = next_row >= cur_height;
   assign pad_calc = 2'd0 - (cur_width[1:0] + cur_width[1:0] + cur_width[1:0]);
   assign pix_y    = COORD_W'(cur_height - DIM_W'(1) - {1'b0, cur_row});
   assign mono_val = byte_ff[3'd7 - bit_ff] ? 8'hFF : 8'h00;

   always_comb begin
      bp_in      = cur_bp;
      ds_in      = cur_ds;
      hs_in      = cur_hs;
      width_in   = cur_width;
      height_in  = cur_height;
      mono_in    = cur_mono;
      phase_in   = cur_phase;
      col_in     = cur_col;
      row_in     = cur_row;
      slot_in    = cur_slot;
      blue_in    = cur_blue;
      green_in   = cur_green;
      pad_in     = cur_pad;
      bit_in     = '0;
      err        = ST_OK;
      res_valid  = 1'b0;
      res_kind   = KIND_PIXEL;
      res_x      = '0;
      res_y      = '0;
      res_red    = '0;
      res_green  = '0;
      res_blue   = '0;
      res_status = ST_OK;
      item_done  = 1'b1;

      unique case (cur_phase)
         PH_HEADER: begin
            if (pos == POS_SIG_B && byte_ff != CHAR_B) begin
               err = ST_NOT_BMP;
            end else if (pos == POS_SIG_M && byte_ff != CHAR_M) begin
               err = ST_NOT_BMP;
            end
            unique case (pos)
               POS_OFFSET_0: ds_in = {24'd0, byte_ff};
               POS_OFFSET_1: ds_in[15:8] = byte_ff;
               POS_OFFSET_2: ds_in[23:16] = byte_ff;
               POS_OFFSET_3: ds_in[31:24] = byte_ff;
               POS_WIDTH_0, POS_HEIGHT_0, POS_DEPTH_0: hs_in = {24'd0, byte_ff};
               POS_WIDTH_1, POS_HEIGHT_1, POS_DEPTH_1: hs_in[15:8] = byte_ff;
               POS_WIDTH_2, POS_HEIGHT_2: hs_in[23:16] = byte_ff;
               POS_WIDTH_3, POS_HEIGHT_3: hs_in[31:24] = byte_ff;
               default: begin
                  if (pos >= POS_COMP_0 && pos <= POS_COMP_3 && byte_ff != 8'd0) begin
                     hs_in[16] = 1'b1;
                  end
               end
            endcase
            if (pos == POS_WIDTH_3) begin
               width_in = clip_dim(hs_in);
            end
            if (pos == POS_HEIGHT_3) begin
               height_in = clip_dim(hs_in);
            end
            if (err == ST_OK && pos == POS_HDR_LAST) begin
               err = check_header(width_in, height_in, hs_in);
            end
            if (err != ST_OK) begin
               res_valid  = 1'b1;
               res_kind   = KIND_ERROR;
               res_status = err;
               phase_in   = PH_ERROR;
            end else begin
               bp_in = cur_bp + 32'd1;
               if (pos == POS_HDR_LAST) begin
                  mono_in  = hs_in[15:0] == DEPTH_MONO;
                  col_in   = '0;
                  row_in   = '0;
                  slot_in  = '0;
                  pad_in   = '0;
                  phase_in = (ds_in > 32'(HEADER_LEN)) ? PH_SKIP : PH_PIXELS;
               end
            end
         end
         PH_SKIP: begin
            bp_in = (cur_bp == '1) ? cur_bp : cur_bp + 32'd1;
            if (bp_in >= cur_ds) begin
               phase_in = PH_PIXELS;
            end
         end
         PH_PIXELS: begin
            if (cur_mono) begin
               res_valid = 1'b1;
               res_x     = cur_col;
               res_y     = pix_y;
               res_red   = mono_val;
               res_green = mono_val;
               res_blue  = mono_val;
            end else if (cur_pad != 2'd0) begin
               pad_in = cur_pad - 2'd1;
            end else if (cur_slot == 2'd0) begin
               blue_in = byte_ff;
               slot_in = 2'd1;
            end else if (cur_slot == 2'd1) begin
               green_in = byte_ff;
               slot_in  = 2'd2;
            end else begin
               res_valid = 1'b1;
               res_x     = cur_col;
               res_y     = pix_y;
               res_red   = byte_ff;
               res_green = cur_green;
               res_blue  = cur_blue;
               slot_in   = 2'd0;
            end
            if (res_valid) begin
               if (col_wrap) begin
                  col_in = '0;
                  if (row_wrap) begin
                     row_in   = '0;
                     phase_in = PH_DONE;
                  end else begin
                     row_in = next_row[COORD_W-1:0];
                     if (!cur_mono) begin
                        pad_in = pad_calc;
                     end
                  end
               end else begin
                  col_in = next_col[COORD_W-1:0];
               end
            end
            if (cur_mono) begin
               item_done = (bit_ff == 3'd7) || (phase_in == PH_DONE);
               bit_in    = item_done ? 3'd0 : bit_ff + 3'd1;
            end
         end
         PH_DONE, PH_ERROR: begin
         end
         default: begin
         end
      endcase
   end

   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign step_go       = in_valid_ff && (!res_valid || out_free);
   assign req_if.ready  = !in_valid_ff || (step_go && item_done);
   assign req_go        = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         start_ff    <= 1'b0;
      end else if (req_go) begin
         in_valid_ff <= 1'b1;
         start_ff    <= req_if.image_start;
      end else if (step_go) begin
         in_valid_ff <= !item_done;
         start_ff    <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         byte_ff <= req_if.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff    <= '0;
         bp_ff     <= '0;
         ds_ff     <= '0;
         hs_ff     <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         mono_ff   <= 1'b0;
         phase_ff  <= PH_HEADER;
         col_ff    <= '0;
         row_ff    <= '0;
         slot_ff   <= '0;
         blue_ff   <= '0;
         green_ff  <= '0;
         pad_ff    <= '0;
      end else if (step_go) begin
         bit_ff    <= bit_in;
         bp_ff     <= bp_in;
         ds_ff     <= ds_in;
         hs_ff     <= hs_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         mono_ff   <= mono_in;
         phase_ff  <= phase_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         slot_ff   <= slot_in;
         blue_ff   <= blue_in;
         green_ff  <= green_in;
         pad_ff    <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_go && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && res_valid) begin
         rsp_kind_ff   <= res_kind;
         rsp_x_ff      <= res_x;
         rsp_y_ff      <= res_y;
         rsp_red_ff    <= res_red;
         rsp_green_ff  <= res_green;
         rsp_blue_ff   <= res_blue;
         rsp_status_ff <= res_status;
         rsp_last_ff   <= item_done;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.kind    = rsp_kind_ff;
   assign rsp_if.pixel_x = rsp_x_ff;
   assign rsp_if.pixel_y = rsp_y_ff;
   assign rsp_if.red     = rsp_red_ff;
   assign rsp_if.green   = rsp_green_ff;
   assign rsp_if.blue    = rsp_blue_ff;
   assign rsp_if.status  = rsp_status_ff;
   assign rsp_if.last    = rsp_last_ff;

   a_bit_only_mono: assert property (@(posedge clock) disable iff (reset)
      bit_ff != 3'd0 |-> mono_ff && phase_ff == PH_PIXELS)
      else $error("bit sequencer active outside 1-bit pixel decoding");

   a_error_stops: assert property (@(posedge clock) disable iff (reset)
      step_go && res_valid && res_kind == KIND_ERROR |=> phase_ff == PH_ERROR)
      else $error("error report did not stop the parser");

   a_done_idle_bits: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |-> bit_ff == 3'd0)
      else $error("bit sequencer left running after the final pixel");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_ERROR |-> rsp_last_ff && rsp_status_ff != ST_OK)
      else $error("error report without status or last flag");

endmodule
